// ===== design/lkr_pkg.sv =====
// lru-k frame replacer package: sizes, command and status codes, word types
// no dependencies
package lkr_pkg;

	localparam int MAX_FRAMES = 64;
	localparam int MAX_K      = 8;
	localparam int FRAME_W    = $clog2(MAX_FRAMES);
	localparam int FCNT_W     = FRAME_W + 1;
	localparam int SLOT_W     = $clog2(MAX_K);
	localparam int CNT_W      = SLOT_W + 1;
	localparam int STAMP_W    = 48;
	localparam int KEY_W      = STAMP_W + 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_W      = 7;

	localparam logic [1:0] CMD_ACCESS = 2'd0;
	localparam logic [1:0] CMD_SET    = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;
	localparam logic [1:0] CMD_EVICT  = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_RANGE   = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;
	localparam logic [1:0] ST_EMPTY   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 1'd1;

	localparam logic [1:0] CLS_FINITE = 2'd0;
	localparam logic [1:0] CLS_INF    = 2'd1;
	localparam logic [1:0] CLS_EMPTY  = 2'd2;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [FRAME_W-1:0] frame;
		logic               make_evictable;
	} in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [FRAME_W-1:0] victim;
		logic [FCNT_W-1:0]  evictable_count;
	} out_t;

	typedef struct packed {
		logic [CNT_W-1:0]  cnt;
		logic [SLOT_W-1:0] head;
	} meta_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic meta_rd;
		logic scan_clr;
		logic scan_rd;
		logic finish;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
	} dp_stat_t;

endpackage

// ===== design/lkr_ctrl.sv =====
// lru-k replacer controller: sequences access, update and evict scan
// depends on lkr_pkg
module lkr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        cmd,
	input  lkr_pkg::dp_stat_t stat,
	output lkr_pkg::dp_cmd_t  ctl,
	output logic              busy
);
	import lkr_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_ACC_RD = 6'b000010,
		S_SCAN   = 6'b000100,
		S_DRAIN1 = 6'b001000,
		S_DRAIN2 = 6'b010000,
		S_FIN    = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.latch = 1'b1;
					case (cmd)
						CMD_ACCESS: state_d = S_ACC_RD;
						CMD_EVICT: begin
							ctl.scan_clr = 1'b1;
							state_d      = S_SCAN;
						end
						default: state_d = S_FIN;
					endcase
				end
			end
			S_ACC_RD: begin
				ctl.meta_rd = 1'b1;
				state_d     = S_FIN;
			end
			S_SCAN: begin
				ctl.scan_rd = 1'b1;
				if (stat.scan_last) state_d = S_DRAIN1;
			end
			S_DRAIN1: state_d = S_DRAIN2;
			S_DRAIN2: state_d = S_FIN;
			S_FIN: begin
				ctl.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== design/lkr_datapath.sv =====
// lru-k replacer datapath: frame flags, history memories, scan pipeline, result
// depends on lkr_pkg
module lkr_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lkr_pkg::in_t                  item,
	input  lkr_pkg::dp_cmd_t              ctl,
	input  logic                          cfg_we,
	input  logic [lkr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lkr_pkg::CFG_W-1:0]     cfg_data,
	output lkr_pkg::dp_stat_t             stat,
	output lkr_pkg::out_t                 result,
	output logic                          done
);
	import lkr_pkg::*;

	// config
	logic [FCNT_W-1:0] lim_cfg_q;
	logic [CNT_W-1:0]  k_cfg_q;
	logic [FCNT_W-1:0] lim;
	logic [CNT_W-1:0]  k_eff;

	in_t               item_q;
	logic [MAX_FRAMES-1:0] known_q, evict_q, meta_vld_q;
	logic [FCNT_W-1:0] total_q;
	logic [STAMP_W-1:0] clock_q;

	// memories
	meta_t              meta_mem [MAX_FRAMES];
	logic [STAMP_W-1:0] stamp_mem [MAX_FRAMES*MAX_K];
	meta_t              meta_rd_q;
	logic               vld_rd_q;
	logic [STAMP_W-1:0] stamp_rd_q;

	logic [FRAME_W-1:0] scan_q;
	logic [FRAME_W-1:0] rd_addr;
	logic               rd_en;

	// scan pipeline
	logic               v_s1, ev_s1, v_s2, ev_s2;
	logic [FRAME_W-1:0] idx_s1, idx_s2;
	logic [1:0]         cls_s2;
	logic [CNT_W-1:0]   cnt_s1;
	logic [SLOT_W-1:0]  head_s1;
	logic [CNT_W-1:0]   back_s1;
	logic [SLOT_W-1:0]  slot_s1;
	logic [1:0]         cls_s1;
	logic [KEY_W-1:0]   key_s2;

	logic               best_vld_q;
	logic [FRAME_W-1:0] best_q;
	logic [KEY_W-1:0]   best_key_q;

	// finish
	logic               acc_ok;
	meta_t              meta_wr;
	logic               meta_we;
	logic               stamp_we;

	assign lim   = (lim_cfg_q > FCNT_W'(MAX_FRAMES)) ? FCNT_W'(MAX_FRAMES) : lim_cfg_q;
	assign k_eff = (k_cfg_q == '0) ? CNT_W'(1) :
	               (k_cfg_q > CNT_W'(MAX_K)) ? CNT_W'(MAX_K) : k_cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_cfg_q <= FCNT_W'(MAX_FRAMES);
			k_cfg_q   <= CNT_W'(2);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAMES: lim_cfg_q <= cfg_data[FCNT_W-1:0];
				REG_DEPTH:  k_cfg_q   <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) item_q <= item;
	end

	// meta read port: scan index or addressed frame
	assign rd_addr = ctl.scan_rd ? scan_q : item_q.frame;
	assign rd_en   = ctl.scan_rd | ctl.meta_rd;
	assign stat.scan_last = (scan_q == FRAME_W'(MAX_FRAMES-1));

	always_ff @(posedge clk) begin
		if (meta_we) meta_mem[item_q.frame] <= meta_wr;
		if (rd_en) meta_rd_q <= meta_mem[rd_addr];
	end

	// stale head of a cleared frame is masked, the ring restarts at slot zero
	always_ff @(posedge clk) begin
		if (stamp_we) stamp_mem[{item_q.frame, head_s1}] <= clock_q;
		stamp_rd_q <= stamp_mem[{idx_s1, slot_s1}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_rd_q <= 1'b0;
		else if (rd_en) vld_rd_q <= meta_vld_q[rd_addr];
	end

	// stage 1: meta data back, form stamp slot
	assign cnt_s1  = vld_rd_q ? meta_rd_q.cnt  : '0;
	assign head_s1 = vld_rd_q ? meta_rd_q.head : '0;
	assign back_s1 = (cnt_s1 < k_eff) ? cnt_s1 : k_eff;
	assign slot_s1 = head_s1 - back_s1[SLOT_W-1:0];
	assign cls_s1  = (cnt_s1 == '0) ? CLS_EMPTY :
	                 (cnt_s1 < k_eff) ? CLS_INF : CLS_FINITE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			if (ctl.scan_clr)     scan_q <= '0;
			else if (ctl.scan_rd) scan_q <= scan_q + 1'b1;
			v_s1 <= ctl.scan_rd;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_q;
		ev_s1  <= evict_q[scan_q];
		idx_s2 <= idx_s1;
		ev_s2  <= ev_s1;
		cls_s2 <= cls_s1;
	end

	// stage 2: age and compare, strict greater keeps the lowest index on ties
	assign key_s2 = {cls_s2, (cls_s2 == CLS_EMPTY) ? STAMP_W'(0) : clock_q - stamp_rd_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_vld_q <= 1'b0;
		end else if (ctl.scan_clr) begin
			best_vld_q <= 1'b0;
		end else if (v_s2 && ev_s2 && (!best_vld_q || key_s2 > best_key_q)) begin
			best_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && ev_s2 && (!best_vld_q || key_s2 > best_key_q)) begin
			best_q     <= idx_s2;
			best_key_q <= key_s2;
		end
	end

	// finish step
	assign acc_ok   = ctl.finish && (item_q.cmd == CMD_ACCESS) && ({1'b0, item_q.frame} < lim);
	assign stamp_we = acc_ok;
	assign meta_we  = acc_ok;
	always_comb begin
		meta_wr.cnt  = (cnt_s1 == CNT_W'(MAX_K)) ? cnt_s1 : cnt_s1 + 1'b1;
		meta_wr.head = head_s1 + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_q    <= '0;
			evict_q    <= '0;
			meta_vld_q <= '0;
			total_q    <= '0;
			clock_q    <= '0;
			done       <= 1'b0;
			result     <= '0;
		end else begin
			done <= ctl.finish;
			if (ctl.finish) begin
				result.status          <= ST_OK;
				result.victim          <= '0;
				result.evictable_count <= total_q;
				case (item_q.cmd)
					CMD_ACCESS: begin
						if (acc_ok) begin
							meta_vld_q[item_q.frame] <= 1'b1;
							known_q[item_q.frame]    <= 1'b1;
							clock_q                  <= clock_q + 1'b1;
						end else begin
							result.status <= ST_RANGE;
						end
					end
					CMD_SET: begin
						if (!known_q[item_q.frame]) begin
							result.status <= ST_UNKNOWN;
						end else if (evict_q[item_q.frame] && !item_q.make_evictable) begin
							evict_q[item_q.frame]  <= 1'b0;
							total_q                <= total_q - 1'b1;
							result.evictable_count <= total_q - 1'b1;
						end else if (!evict_q[item_q.frame] && item_q.make_evictable) begin
							evict_q[item_q.frame]  <= 1'b1;
							total_q                <= total_q + 1'b1;
							result.evictable_count <= total_q + 1'b1;
						end
					end
					CMD_REMOVE: begin
						if (!known_q[item_q.frame]) begin
							result.status <= ST_UNKNOWN;
						end else if (evict_q[item_q.frame]) begin
							evict_q[item_q.frame]    <= 1'b0;
							meta_vld_q[item_q.frame] <= 1'b0;
							total_q                  <= total_q - 1'b1;
							result.evictable_count   <= total_q - 1'b1;
						end
					end
					CMD_EVICT: begin
						if (best_vld_q) begin
							evict_q[best_q]        <= 1'b0;
							meta_vld_q[best_q]     <= 1'b0;
							total_q                <= total_q - 1'b1;
							result.evictable_count <= total_q - 1'b1;
							result.victim          <= best_q;
						end else begin
							result.status <= ST_EMPTY;
						end
					end
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== design/lru_k_frame_replacer_unit.sv =====
// lru-k frame replacer top level: controller plus datapath
// depends on lkr_pkg, lkr_ctrl, lkr_datapath
//
// A command word is taken when start is high and busy is low; exactly one
// result word follows, shown for a single cycle with done high, and the
// receiver must take it then as there is no way to hold it off. The evict
// scan reads every frame's history bookkeeping and one stamp per frame,
// one frame per cycle through the single read port of each history
// memory, then passes the drain states S_DRAIN1 and S_DRAIN2 to empty the
// age compare pipeline. There is no clearing pass after reset; stamps are
// only read once written. Configuration writes are always ready and belong
// while the block is idle.
module lru_k_frame_replacer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  lkr_pkg::in_t                  item,
	output lkr_pkg::out_t                 result,
	output logic                          done,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lkr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lkr_pkg::CFG_W-1:0]     cfg_data
);
	import lkr_pkg::*;

	dp_cmd_t  ctl;
	dp_stat_t stat;

	// registers take a word in any cycle
	assign cfg_ready = 1'b1;

	lkr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (item.cmd),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	lkr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.ctl       (ctl),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.result    (result),
		.done      (done)
	);

	// a taken word makes the block busy next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	// result strobe only once the controller is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// failed evict reports frame zero
	a_empty_victim: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_EMPTY |-> result.victim == '0)
		else $error("victim set on empty evict");

	// evictable count never exceeds the frame count
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.evictable_count <= FCNT_W'(MAX_FRAMES))
		else $error("evictable count out of range");

endmodule

// ===== tb/sv/lru_k_frame_replacer_unit_tb.sv =====
// testbench for the lru-k frame replacer: directed and random command words
// checked against a behavioural replacement predictor; depends on lkr_pkg and the dut
module lru_k_frame_replacer_unit_tb;
	import lkr_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_t item = '0;
	out_t result;
	logic done;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	always #5 clk = ~clk;

	lru_k_frame_replacer_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result(result), .done(done), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state, mirrors the block's bookkeeping
	int unsigned lim_reg;
	int unsigned depth_reg;
	bit known_q[MAX_FRAMES];
	bit evict_q[MAX_FRAMES];
	logic [STAMP_W-1:0] stamps_q[MAX_FRAMES][MAX_K];
	int unsigned hcount_q[MAX_FRAMES];
	int unsigned hhead_q[MAX_FRAMES];
	logic [STAMP_W-1:0] clock_q;
	int unsigned evict_total;

	in_t pending_words[$];
	out_t expected_results[$];
	int unsigned mismatches = 0;
	int unsigned checked = 0;
	int unsigned evicts_seen = 0;
	longint unsigned cycles = 0;
	bit stim_done = 1'b0;
	bit quiet = 1'b0;

	function automatic logic [STAMP_W-1:0] stamp_age(int unsigned f, int unsigned back);
		int unsigned slot;
		slot = (hhead_q[f] + MAX_K - back) % MAX_K;
		return clock_q - stamps_q[f][slot];
	endfunction

	// apply one command to the predictor and return the expected word
	function automatic out_t replace_step(in_t w);
		out_t r;
		int unsigned f, lim, k, cls, best_cls;
		int best;
		logic [STAMP_W-1:0] age, best_age;
		r = '0;
		f = w.frame;
		case (w.cmd)
			CMD_ACCESS: begin
				lim = lim_reg > MAX_FRAMES ? MAX_FRAMES : lim_reg;
				if (f >= lim) begin
					r.status = ST_RANGE;
				end else begin
					stamps_q[f][hhead_q[f]] = clock_q;
					hhead_q[f] = (hhead_q[f] + 1) % MAX_K;
					if (hcount_q[f] < MAX_K) hcount_q[f]++;
					known_q[f] = 1'b1;
					clock_q = clock_q + 1'b1;
				end
			end
			CMD_SET, CMD_REMOVE: begin
				if (!known_q[f]) begin
					r.status = ST_UNKNOWN;
				end else if (w.cmd == CMD_SET) begin
					if (evict_q[f] && !w.make_evictable) begin
						evict_q[f] = 1'b0;
						evict_total--;
					end else if (!evict_q[f] && w.make_evictable) begin
						evict_q[f] = 1'b1;
						evict_total++;
					end
				end else if (evict_q[f]) begin
					evict_q[f] = 1'b0;
					hcount_q[f] = 0;
					hhead_q[f] = 0;
					evict_total--;
				end
			end
			default: begin
				k = depth_reg < 1 ? 1 : (depth_reg > MAX_K ? MAX_K : depth_reg);
				best = -1;
				best_cls = 0;
				best_age = '0;
				for (int i = 0; i < MAX_FRAMES; i++) begin
					if (!evict_q[i]) continue;
					if (hcount_q[i] == 0) begin
						cls = 2;
						age = '0;
					end else if (hcount_q[i] < k) begin
						cls = 1;
						age = stamp_age(i, hcount_q[i]);
					end else begin
						cls = 0;
						age = stamp_age(i, k);
					end
					if (best < 0 || cls > best_cls || (cls == best_cls && age > best_age)) begin
						best = i;
						best_cls = cls;
						best_age = age;
					end
				end
				if (best < 0) begin
					r.status = ST_EMPTY;
				end else begin
					evict_q[best] = 1'b0;
					hcount_q[best] = 0;
					hhead_q[best] = 0;
					evict_total--;
					r.victim = FRAME_W'(best);
				end
			end
		endcase
		r.evictable_count = FCNT_W'(evict_total);
		return r;
	endfunction

	function automatic void queue_word(in_t w);
		pending_words.insert(pending_words.size(), w);
	endfunction

	// driver: takes words from the pending queue, idles now and then
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (start && !busy) begin
				expected_results.insert(expected_results.size(), replace_step(item));
				pending_words.delete(0);
			end
			if (start && busy) begin
				// hold the word until taken
			end else if (pending_words.size() > 0 &&
					(quiet || $urandom_range(99) >= 10)) begin
				start <= 1'b1;
				item <= pending_words[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: every done cycle carries one result word
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %p", result);
			end else begin
				out_t e;
				e = expected_results[0];
				expected_results.delete(0);
				checked++;
				if (e.status == ST_OK && result.victim != e.victim) evicts_seen += 0;
				if (result.status !== e.status || result.victim !== e.victim ||
						result.evictable_count !== e.evictable_count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p got %p", e, result);
				end
			end
		end
	end

	// timeout guard
	always @(posedge clk) begin
		if (cycles > 2000000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_words.size() != 0 || start || expected_results.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_FRAMES) lim_reg = val & 32'h7F;
		else depth_reg = val & 32'hF;
	endtask

	function automatic in_t mk_word(logic [1:0] c, int unsigned f, bit m);
		in_t w;
		w.cmd = c;
		w.frame = FRAME_W'(f);
		w.make_evictable = m;
		return w;
	endfunction

	// random phase biased towards well-formed access / mark / evict sequences
	task automatic random_phase(int unsigned n, int unsigned span);
		int unsigned f, sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			f = (sel < 90) ? $urandom_range(span - 1) : $urandom_range(63);
			if (sel < 45) queue_word(mk_word(CMD_ACCESS, f, $urandom_range(1)));
			else if (sel < 70) queue_word(mk_word(CMD_SET, f, $urandom_range(3) != 0));
			else if (sel < 78) queue_word(mk_word(CMD_REMOVE, f, $urandom_range(1)));
			else queue_word(mk_word(CMD_EVICT, $urandom_range(63), $urandom_range(1)));
		end
	endtask

	initial begin
		lim_reg = 64;
		depth_reg = 2;
		clock_q = '0;
		evict_total = 0;
		for (int i = 0; i < MAX_FRAMES; i++) begin
			known_q[i] = 0;
			evict_q[i] = 0;
			hcount_q[i] = 0;
			hhead_q[i] = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		// directed: unknown frames, empty evict, extremes, empty-history winner
		queue_word(mk_word(CMD_EVICT, 0, 0));
		queue_word(mk_word(CMD_SET, 63, 1));
		queue_word(mk_word(CMD_REMOVE, 0, 0));
		queue_word(mk_word(CMD_ACCESS, 63, 1));
		queue_word(mk_word(CMD_ACCESS, 0, 0));
		queue_word(mk_word(CMD_ACCESS, 0, 0));
		queue_word(mk_word(CMD_ACCESS, 5, 0));
		queue_word(mk_word(CMD_SET, 63, 1));
		queue_word(mk_word(CMD_SET, 0, 1));
		queue_word(mk_word(CMD_SET, 5, 1));
		queue_word(mk_word(CMD_SET, 5, 1));
		queue_word(mk_word(CMD_EVICT, 0, 0));
		queue_word(mk_word(CMD_SET, 63, 1));
		queue_word(mk_word(CMD_REMOVE, 5, 0));
		queue_word(mk_word(CMD_SET, 5, 1));
		queue_word(mk_word(CMD_EVICT, 0, 0));
		queue_word(mk_word(CMD_SET, 0, 0));
		queue_word(mk_word(CMD_REMOVE, 0, 0));
		queue_word(mk_word(CMD_EVICT, 0, 0));
		queue_word(mk_word(CMD_EVICT, 0, 0));
		wait_drained();
		// sweep settings, extremes included, draining between writes
		write_reg(REG_FRAMES, 1);
		write_reg(REG_DEPTH, 1);
		random_phase(150, 2);
		wait_drained();
		write_reg(REG_FRAMES, 0);
		random_phase(40, 4);
		wait_drained();
		write_reg(REG_FRAMES, 127);
		write_reg(REG_DEPTH, 8);
		quiet = 1'b1;
		random_phase(300, 12);
		wait_drained();
		quiet = 1'b0;
		write_reg(REG_DEPTH, 0);
		random_phase(250, 8);
		wait_drained();
		write_reg(REG_DEPTH, 15);
		write_reg(REG_FRAMES, 64);
		random_phase(250, 16);
		wait_drained();
		write_reg(REG_FRAMES, 40);
		write_reg(REG_DEPTH, 3);
		random_phase(400, 48);
		wait_drained();
		write_reg(REG_FRAMES, 64);
		write_reg(REG_DEPTH, 2);
		random_phase(500, 64);
		wait_drained();
		$display("ran directed words and random access/mark/remove/evict traffic");
		$display("%0d result words checked over frame limits 0..127 and depths 0..15", checked);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
design/lkr_pkg.sv
design/lkr_ctrl.sv
design/lkr_datapath.sv
design/lru_k_frame_replacer_unit.sv
tb/sv/lru_k_frame_replacer_unit_tb.sv
